// ===== rtl/cps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and codes for the CPU process scheduler.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Number of process slots; process numbers are 5 bits wide.
  localparam int MAX_PROCS = 32;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_RR   = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SLICE = 2'd1;
  localparam logic [1:0] REG_TASKS = 2'd2;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Command broadcast to every cell of the ready queue.
  typedef struct packed {
    logic push;   // append a process at the tail
    logic take;   // remove the entry whose position matches take_pos
  } cell_cmd_t;

  // Result of one tick.
  typedef struct packed {
    logic [15:0] now;
    logic        all_done;
    logic        finished;
    logic        first_run;
    logic        idle;
    logic [4:0]  run_pid;
  } tick_res_t;

endpackage

// ===== rtl/cps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_cell
// One slot of the ready queue: holds a process number, shifts toward the head.
// ----------------------------------------------------------------------------
module cps_cell #(
  parameter int ID_W  = 5,
  parameter int POS_W = 5
) (
  input  logic                 clk,
  input  cps_pkg::cell_cmd_t   cmd,
  input  logic [POS_W-1:0]     my_pos,
  input  logic [POS_W:0]       count,
  input  logic [POS_W-1:0]     take_pos,
  input  logic [ID_W-1:0]      push_id,
  input  logic [ID_W-1:0]      up_id,
  output logic [ID_W-1:0]      id
);
  import cps_pkg::*;

  logic [ID_W-1:0] id_next;
  logic            at_tail;
  logic            shift;

  assign at_tail = ({1'b0, my_pos} == count);
  assign shift   = cmd.take && (my_pos >= take_pos);

  always_comb begin
    id_next = id;
    if (shift) begin
      id_next = up_id;
    end
    if (cmd.push && at_tail) begin
      id_next = push_id;
    end
  end

  // Payload only: the queue count decides which cells hold live entries.
  always_ff @(posedge clk) begin
    id <= id_next;
  end
endmodule

// ===== rtl/cps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_queue
// Ready queue built as a row of cells with occupancy count.
// ----------------------------------------------------------------------------
module cps_queue #(
  parameter int DEPTH = 32,
  parameter int ID_W  = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cps_pkg::cell_cmd_t            cmd,
  input  logic [$clog2(DEPTH)-1:0]      take_pos,
  input  logic [ID_W-1:0]               push_id,
  output logic [$clog2(DEPTH):0]        count,
  output logic [ID_W-1:0]               ids [DEPTH]
);
  import cps_pkg::*;
  localparam int POS_W = $clog2(DEPTH);

  logic [POS_W:0] count_next;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_W-1:0] up;
    if (g == DEPTH - 1) begin : g_last
      assign up = ids[g];
    end else begin : g_mid
      assign up = ids[g+1];
    end
    cps_cell #(.ID_W(ID_W), .POS_W(POS_W)) u_cell (
      .clk(clk), .cmd(cmd), .my_pos(POS_W'(g)), .count(count),
      .take_pos(take_pos), .push_id(push_id), .up_id(up), .id(ids[g])
    );
  end

  // A push in the same cycle as a take would write cell count, not count-1 after the shift;
  // the controller never issues both together.
  always_comb begin
    count_next = count;
    if (cmd.push && count != (POS_W+1)'(DEPTH)) begin
      count_next = count + 1'b1;
    end else if (cmd.take && count != '0) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (POS_W+1)'(DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) !(cmd.push && cmd.take))
    else $error("push and take together");
  assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> count == $past(count) - 1'b1)
    else $error("take did not shrink queue");
endmodule

// ===== rtl/cpu_process_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_process_scheduler
// Tick-driven FCFS / SJF / round-robin CPU scheduler.
// ----------------------------------------------------------------------------
// The ready list is a row of cells that shift toward the head when an entry
// is taken. One item is handled at a time. An arrival first runs a duplicate
// scan over the queued entries, one cell per cycle, and then the push; with
// an empty queue the scan has no cells to walk. A tick passes through pick,
// memory read, execute and output, with an extra pick pass when a preempted
// process must be requeued first. In SJF mode with nothing running the pick
// scans the queue one cell per cycle for the shortest burst. FCFS and RR
// take the head directly. The result waits in an output register; input
// and register writes are taken again only once it is delivered. Per-process
// burst, used ticks and started flag live in small memories read at one
// address per cycle; used ticks and started flags are cleared on arrival, so
// no clearing pass is needed after reset.
module cpu_process_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] proc_id, [12:5] burst, [15:13] zero
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] run_pid [5] idle [6] first_run
                                 // [7] finished [23:8] now
  output logic        m_tuser,   // all_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cps_pkg::*;

  localparam int POS_W = $clog2(MAX_PROCS);
  localparam int ID_W  = 5;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_RUN2 = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state;

  logic [1:0] sched_mode;
  logic [7:0] slice_len;
  logic [5:0] task_count;

  logic       in_func;
  logic [4:0] in_pid;
  logic [7:0] in_burst;

  cell_cmd_t         cmd;
  logic [POS_W-1:0]  take_pos;
  logic [ID_W-1:0]   push_id;
  logic [POS_W:0]    count;
  logic [ID_W-1:0]   ids [MAX_PROCS];

  logic [POS_W:0]    scan_i;
  logic              dup;
  logic [POS_W-1:0]  best_pos;
  logic [7:0]        best_burst;
  logic [ID_W-1:0]   best_id;

  logic              run_valid;
  logic [ID_W-1:0]   run_id;
  logic [7:0]        slice_left;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic [15:0]       clock_count;
  logic [5:0]        done_count;

  logic [7:0]        burst_mem [MAX_PROCS];
  logic [7:0]        used_mem  [MAX_PROCS];
  logic              start_mem [MAX_PROCS];
  logic [7:0]        rd_burst;
  logic [7:0]        rd_used;
  logic              rd_start;
  logic [ID_W-1:0]   rd_addr;

  logic [ID_W-1:0]   scan_id;
  logic [7:0]        scan_burst;

  logic              arr_ok;    // arrival is new, nonzero and fits
  logic              pick_now;  // take a process from the queue this cycle
  logic              fin_now;   // running process uses its last tick

  tick_res_t         res;

  assign s_tready  = (state == ST_IDLE) && !m_tvalid;
  assign cfg_ready = (state == ST_IDLE) && !m_tvalid;
  assign scan_id   = ids[scan_i[POS_W-1:0]];

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= MODE_FCFS;
      slice_len  <= 8'd1;
      task_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:  sched_mode <= cfg_data[1:0];
        REG_SLICE: slice_len  <= cfg_data;
        REG_TASKS: task_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Memory read address: scan walks queue entries, run reads the runner.
  always_comb begin
    rd_addr = run_id;
    if (state == ST_SCAN) begin
      rd_addr = scan_id;
    end
  end

  always_ff @(posedge clk) begin
    rd_burst <= burst_mem[rd_addr];
    rd_used  <= used_mem[rd_addr];
    rd_start <= start_mem[rd_addr];
  end
  assign scan_burst = rd_burst;

  // Drop an arrival that is already queued, running or pending requeue, has a zero burst or finds the queue full.
  assign arr_ok = !in_func && !dup && in_burst != 8'd0
                  && count != (POS_W+1)'(MAX_PROCS)
                  && !(run_valid && run_id == in_pid)
                  && !(pend_valid && pend_id == in_pid);

  // SJF picks only after the scan has walked the queue.
  assign pick_now = !pend_valid && !run_valid && count != '0 &&
                    !(sched_mode == MODE_SJF && scan_i == '0);

  assign fin_now = ((rd_used + 8'd1) == rd_burst);

  always_comb begin
    cmd      = '0;
    take_pos = best_pos;
    push_id  = in_pid;
    if (state == ST_PUSH && arr_ok) begin
      cmd.push = 1'b1;
    end
    if (state == ST_PICK && pend_valid) begin
      cmd.push = 1'b1;
      push_id  = pend_id;
    end
    if (state == ST_PICK && pick_now) begin
      cmd.take = 1'b1;
    end
  end

  cps_queue #(.DEPTH(MAX_PROCS), .ID_W(ID_W)) u_queue (
    .clk(clk), .rst(rst), .cmd(cmd), .take_pos(take_pos), .push_id(push_id),
    .count(count), .ids(ids)
  );

  logic [ID_W-1:0] prev_scan_id;
  logic [POS_W:0]  prev_i;
  logic            prev_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      run_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      clock_count <= '0;
      done_count  <= '0;
      scan_i      <= '0;
      prev_v      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            in_func  <= s_tuser;
            in_pid   <= s_tdata[4:0];
            in_burst <= s_tdata[12:5];
            dup      <= 1'b0;
            scan_i   <= '0;
            prev_v   <= 1'b0;
            best_burst <= 8'hFF;
            best_id  <= '1;
            best_pos <= '0;
            state    <= s_tuser ? ST_PICK : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // one cell per cycle; memory data for the previous cell arrives now
          if (prev_v && in_func) begin
            if (scan_burst < best_burst ||
                (scan_burst == best_burst && prev_scan_id < best_id)) begin
              best_burst <= scan_burst;
              best_id    <= prev_scan_id;
              best_pos   <= prev_i[POS_W-1:0];
            end
          end
          if (scan_i < count) begin
            if (!in_func && scan_id == in_pid) begin
              dup <= 1'b1;
            end
            prev_scan_id <= scan_id;
            prev_i       <= scan_i;
            prev_v       <= 1'b1;
            scan_i       <= scan_i + 1'b1;
          end else begin
            prev_v <= 1'b0;
            if (!prev_v) begin
              state <= in_func ? ST_PICK : ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          state <= ST_IDLE;
        end
        ST_PICK: begin
          if (pend_valid) begin
            pend_valid <= 1'b0;
          end else if (!run_valid && count != '0 &&
                       sched_mode == MODE_SJF && !prev_v && scan_i == '0) begin
            state  <= ST_SCAN;
            prev_v <= 1'b0;
          end else begin
            if (pick_now) begin
              run_id     <= (sched_mode == MODE_SJF) ? ids[best_pos] : ids[0];
              run_valid  <= 1'b1;
              slice_left <= (slice_len == '0) ? 8'd1 : slice_len;
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: state <= ST_RUN2;
        ST_RUN2: begin
          res.now     <= clock_count;
          clock_count <= clock_count + 16'd1;
          if (run_valid) begin
            res.run_pid   <= run_id;
            res.idle      <= 1'b0;
            res.first_run <= !rd_start;
            res.finished  <= fin_now;
            if (slice_left != '0) begin
              slice_left <= slice_left - 8'd1;
            end
            if (fin_now) begin
              run_valid <= 1'b0;
              if (done_count != 6'd63) begin
                done_count <= done_count + 6'd1;
              end
            end else if (sched_mode == MODE_RR && slice_left <= 8'd1) begin
              pend_valid <= 1'b1;
              pend_id    <= run_id;
              run_valid  <= 1'b0;
            end
          end else begin
            res.run_pid   <= '0;
            res.idle      <= 1'b1;
            res.first_run <= 1'b0;
            res.finished  <= 1'b0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // done_count already holds the count after this tick
          res.all_done <= (done_count == task_count);
          m_tvalid     <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // SJF scan re-entry: distinguish pre-scan from post-scan pick
  // scan_i is nonzero after the scan walked at least one cell.

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && arr_ok) begin
      burst_mem[in_pid] <= in_burst;
      used_mem[in_pid]  <= '0;
      start_mem[in_pid] <= 1'b0;
    end else if (state == ST_RUN2 && run_valid) begin
      used_mem[run_id]  <= rd_used + 8'd1;
      start_mem[run_id] <= 1'b1;
    end
  end

  assign m_tdata = {res.now, res.finished, res.first_run, res.idle, res.run_pid};
  assign m_tuser = res.all_done;

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input taken while result waits");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN2 && !run_valid) |=> res.idle)
    else $error("idle tick not flagged");
  assert property (@(posedge clk) disable iff (rst)
    !(run_valid && pend_valid && run_id == pend_id))
    else $error("process both running and pending");
endmodule

// ===== test/cpu_process_scheduler_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_process_scheduler_chk
// Watches the arrival/tick, result and register channels of the scheduler,
// predicts each tick result and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module cpu_process_scheduler_chk
  import cps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  tick_res_t   tick_q[$];
  logic [4:0]  ready_q[$];
  logic [7:0]  burst_len[32];
  logic [7:0]  ran_ticks[32];
  logic        has_run[32];
  logic        cpu_busy;
  logic [4:0]  cpu_pid;
  logic [7:0]  quantum_left;
  logic        requeue_on;
  logic [4:0]  requeue_pid;
  logic [15:0] tick_clock;
  logic [5:0]  completed;
  logic [1:0]  mode;
  logic [7:0]  quantum;
  logic [5:0]  task_goal;

  function automatic bit is_known(logic [4:0] p);
    if (cpu_busy && cpu_pid == p) return 1;
    if (requeue_on && requeue_pid == p) return 1;
    foreach (ready_q[i]) if (ready_q[i] == p) return 1;
    return 0;
  endfunction

  task automatic admit(logic [4:0] p, logic [7:0] len);
    if (len == 0 || is_known(p) || ready_q.size() >= 32) return;
    burst_len[p] = len;
    ran_ticks[p] = 0;
    has_run[p]   = 0;
    ready_q = {ready_q, p};
  endtask

  task automatic run_tick();
    tick_res_t r;
    int        pos;
    r = '0;
    r.idle = 1;
    r.now  = tick_clock;
    if (requeue_on) begin
      ready_q = {ready_q, requeue_pid};
      requeue_on = 0;
    end
    if (!cpu_busy && ready_q.size() > 0) begin
      pos = 0;
      if (mode == MODE_SJF) begin
        for (int i = 1; i < ready_q.size(); i++) begin
          if (burst_len[ready_q[i]] < burst_len[ready_q[pos]] ||
              (burst_len[ready_q[i]] == burst_len[ready_q[pos]] &&
               ready_q[i] < ready_q[pos])) pos = i;
        end
      end
      cpu_pid = ready_q[pos];
      ready_q.delete(pos);
      cpu_busy = 1;
      quantum_left = (quantum == 0) ? 8'd1 : quantum;
    end
    if (cpu_busy) begin
      r.run_pid = cpu_pid;
      r.idle    = 0;
      if (!has_run[cpu_pid]) begin
        has_run[cpu_pid] = 1;
        r.first_run = 1;
      end
      ran_ticks[cpu_pid] = ran_ticks[cpu_pid] + 8'd1;
      if (quantum_left > 0) quantum_left--;
      if (ran_ticks[cpu_pid] == burst_len[cpu_pid]) begin
        r.finished = 1;
        cpu_busy   = 0;
        if (completed < 6'd63) completed++;
      end else if (mode == MODE_RR && quantum_left == 0) begin
        requeue_on  = 1;
        requeue_pid = cpu_pid;
        cpu_busy    = 0;
      end
    end
    tick_clock++;
    r.all_done = (completed == task_goal);
    tick_q = {tick_q, r};
  endtask

  always @(posedge clk) begin
    tick_res_t got, want;
    if (rst) begin
      tick_q.delete();
      ready_q.delete();
      foreach (ran_ticks[i]) begin
        ran_ticks[i] = 0;
        has_run[i]   = 0;
        burst_len[i] = 0;
      end
      cpu_busy = 0; cpu_pid = 0; quantum_left = 0;
      requeue_on = 0; requeue_pid = 0; tick_clock = 0; completed = 0;
      mode = MODE_FCFS; quantum = 8'd1; task_goal = 0;
      fail_count = 0; checked = 0; pending = 0;
    end else begin
      // Result side first: a result can never belong to a tick accepted
      // at this same edge.
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:8], m_tuser, m_tdata[7], m_tdata[6], m_tdata[5],
               m_tdata[4:0]};
        checked++;
        if (tick_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result: pid=%0d idle=%0d now=%0d",
                     $realtime, got.run_pid, got.idle, got.now);
        end else begin
          want = tick_q[0];
          tick_q.delete(0);
          if (got.run_pid != want.run_pid || got.idle != want.idle ||
              got.first_run != want.first_run || got.finished != want.finished ||
              got.now != want.now || got.all_done != want.all_done) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch exp pid=%0d idle=%0d first=%0d fin=%0d now=%0d done=%0d",
                       $realtime, want.run_pid, want.idle, want.first_run,
                       want.finished, want.now, want.all_done);
              $display("        got pid=%0d idle=%0d first=%0d fin=%0d now=%0d done=%0d",
                       got.run_pid, got.idle, got.first_run, got.finished,
                       got.now, got.all_done);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  mode      = cfg_data[1:0];
          REG_SLICE: quantum   = cfg_data;
          REG_TASKS: task_goal = cfg_data[5:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_TICK) run_tick();
        else admit(s_tdata[4:0], s_tdata[12:5]);
      end
      pending = tick_q.size();
    end
  end

endmodule

// ===== test/cpu_process_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_process_scheduler_tb
// Drives arrivals and ticks through FCFS, SJF, round robin and odd register
// settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module cpu_process_scheduler_tb;
  import cps_pkg::*;

  localparam int IDLE_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int SETTLE_WAIT = 60;    // covers an arrival still in flight

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;     // [4:0] proc_id, [12:5] burst, [15:13] zero
  logic        s_tuser;     // func
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;     // run_pid, idle, first_run, finished, now
  logic        m_tuser;     // all_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int fail_count, pending, checked;
  int n_ticks, n_arrivals, idle_cycles;

  cpu_process_scheduler i_dut (.*);

  cpu_process_scheduler_chk i_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Draw a gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: hold ready low for random stretches.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready   <= 1;
      stall_left <= gap_len();
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one item and wait for it to be taken; drop valid only for a gap.
  task automatic send(logic fn, logic [4:0] pid, logic [7:0] len);
    int g;
    s_tvalid   <= 1;
    s_tuser    <= fn;
    s_tdata    <= {3'b000, len, pid};
    do @(posedge clk); while (!s_tready);
    if (fn == FUNC_TICK) n_ticks++;
    else n_arrivals++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic tick();
    send(FUNC_TICK, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
  endtask

  // Hold stimulus until every expected result is back, then let any
  // arrival still being scanned settle.
  task automatic drain();
    s_tvalid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic setup(logic [7:0] m, logic [7:0] q, logic [7:0] goal);
    drain();
    write_reg(REG_MODE, m);
    write_reg(REG_SLICE, q);
    write_reg(REG_TASKS, goal);
  endtask

  // Burst lengths: mostly short, some medium, a few long, now and then zero.
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'd0;
    if (r < 70) return 8'($urandom_range(1, 6));
    if (r < 95) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(41, 255));
  endfunction

  // One scheduling time step: arrivals in rising pid order, then ticks.
  // Now and then throw in a duplicate; ticks carry random pid and burst noise.
  task automatic time_step(inout int budget);
    int rate;
    rate = $urandom_range(6, 40);
    for (int p = 0; p < 32 && budget > 0; p++) begin
      if ($urandom_range(0, rate) == 0) begin
        send(FUNC_ARRIVE, p[4:0], pick_len());
        budget--;
        if ($urandom_range(0, 15) == 0) begin
          send(FUNC_ARRIVE, p[4:0], pick_len());
          budget--;
        end
      end
    end
    repeat ($urandom_range(1, 4)) begin
      if (budget > 0) begin
        tick();
        budget--;
      end
    end
  endtask

  task automatic random_phase(int items);
    int budget;
    budget = items;
    while (budget > 0) time_step(budget);
  endtask

  initial begin
    rst        = 1;
    s_tvalid   = 0;
    s_tuser    = 0;
    s_tdata    = 0;
    cfg_valid  = 0;
    cfg_index  = 0;
    cfg_data   = 0;
    n_ticks    = 0;
    n_arrivals = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: idle tick, field extremes, zero burst, duplicate, SJF ties.
    tick();
    send(FUNC_ARRIVE, 5'd0, 8'd1);
    send(FUNC_ARRIVE, 5'd31, 8'd255);
    send(FUNC_ARRIVE, 5'd7, 8'd0);
    send(FUNC_ARRIVE, 5'd31, 8'd3);
    tick();
    tick();
    setup(MODE_SJF, 8'd1, 8'd3);
    send(FUNC_ARRIVE, 5'd3, 8'd2);
    send(FUNC_ARRIVE, 5'd9, 8'd2);
    send(FUNC_ARRIVE, 5'd10, 8'd1);
    repeat (4) tick();
    // Change the mode mid-run and use the unused mode value.
    drain();
    write_reg(REG_MODE, MODE_RR);
    repeat (3) tick();
    setup(8'd3, 8'd0, 8'd63);
    send(FUNC_ARRIVE, 5'd0, 8'd2);
    send(FUNC_ARRIVE, 5'd3, 8'd170);
    repeat (4) tick();

    // Random phases across the settings, extremes included.
    setup(MODE_RR, 8'd1, 8'd10);
    random_phase(130);
    setup(MODE_FCFS, 8'd1, 8'd32);
    random_phase(120);
    setup(MODE_SJF, 8'd4, 8'd0);
    random_phase(130);
    // Pause until the results catch up, then carry on without new settings.
    drain();
    random_phase(60);
    setup(MODE_RR, 8'd255, 8'd20);
    random_phase(120);
    setup(MODE_RR, 8'd3, 8'd40);
    random_phase(80);
    setup(MODE_RR, 8'd0, 8'd63);
    random_phase(100);
    setup(MODE_SJF, 8'd2, 8'd255);
    random_phase(110);

    drain();
    $display("Covered %0d arrivals and %0d ticks in FCFS, SJF, RR and mode 3,",
             n_arrivals, n_ticks);
    $display("slices 0..255, several task counts; %0d results compared.", checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cps_pkg.sv
rtl/cps_cell.sv
rtl/cps_queue.sv
rtl/cpu_process_scheduler.sv
test/cpu_process_scheduler_chk.sv
test/cpu_process_scheduler_tb.sv
